// ===== design/sem_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_pkg
// shared types and constants of the sobel edge magnitude block
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int CH_W             = 8;
    localparam int PIX_W            = 3 * CH_W;
    localparam int G_W              = 12;
    localparam int S_W              = 21;
    localparam int CFG_IDX_W        = 8;
    localparam int CFG_DATA_W       = 13;
    localparam int WIDTH_FIELD_W    = 11;
    localparam int HEIGHT_FIELD_W   = 13;
    localparam int IROW_W           = 13;
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_HEIGHT   = 4096;
    localparam int RESET_WIDTH      = 640;
    localparam int RESET_HEIGHT     = 480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // pixel: red in the lowest byte, then green, then blue
    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic row_top;
        logic row_bot;
        logic col_left;
        logic col_right;
    } t_border;

    typedef logic [2:0][S_W-1:0]  t_sq;
    typedef logic [2:0][CH_W-1:0] t_mag;

endpackage
`default_nettype wire

// ===== design/sem_line_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_line_mem
// two line stores side by side in one memory, registered read
// ----------------------------------------------------------------------------
module sem_line_mem #(
    parameter int DEPTH = sem_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire                          i_clk,
    input  wire  [ADDR_W-1:0]            i_rd_addr,
    output logic [2*sem_pkg::PIX_W-1:0]  o_rd_data,   // middle line low, upper line high
    input  wire                          i_wr_en,
    input  wire  [ADDR_W-1:0]            i_wr_addr,
    input  wire  [2*sem_pkg::PIX_W-1:0]  i_wr_data
);

    logic [2*sem_pkg::PIX_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== design/sem_grad.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_grad
// 3x3 window and per-channel sum of squared sobel gradients
// ----------------------------------------------------------------------------
module sem_grad (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_shift,
    input  sem_pkg::t_pix      i_upper,
    input  sem_pkg::t_pix      i_middle,
    input  sem_pkg::t_pix      i_px,
    input  sem_pkg::t_border   i_border,
    output sem_pkg::t_sq       o_sq
);

    sem_pkg::t_pix r_win [3][3];

    function automatic logic signed [sem_pkg::G_W-1:0] tap(sem_pkg::t_pix p, int ch,
                                                           logic ok);
        logic [sem_pkg::CH_W-1:0] v;
        v = p[ch*sem_pkg::CH_W +: sem_pkg::CH_W];
        return ok ? $signed({{(sem_pkg::G_W-sem_pkg::CH_W){1'b0}}, v})
                  : '0;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= i_upper;
            r_win[1][2] <= i_middle;
            r_win[2][2] <= i_px;
        end
    end

    always_comb begin
        logic signed [sem_pkg::G_W-1:0]   t00, t01, t02, t10, t12, t20, t21, t22;
        logic signed [sem_pkg::G_W-1:0]   gx, gy;
        logic signed [2*sem_pkg::G_W-1:0] px2, py2;
        for (int ch = 0; ch < 3; ch++) begin
            t00 = tap(r_win[0][0], ch, i_border.row_top & i_border.col_left);
            t01 = tap(r_win[0][1], ch, i_border.row_top);
            t02 = tap(r_win[0][2], ch, i_border.row_top & i_border.col_right);
            t10 = tap(r_win[1][0], ch, i_border.col_left);
            t12 = tap(r_win[1][2], ch, i_border.col_right);
            t20 = tap(r_win[2][0], ch, i_border.row_bot & i_border.col_left);
            t21 = tap(r_win[2][1], ch, i_border.row_bot);
            t22 = tap(r_win[2][2], ch, i_border.row_bot & i_border.col_right);
            gx  = (t02 - t00) + ((t12 - t10) <<< 1) + (t22 - t20);
            gy  = (t20 + t22 - t00 - t02) + ((t21 - t01) <<< 1);
            px2 = gx * gx;
            py2 = gy * gy;
            o_sq[ch] = sem_pkg::S_W'(px2) + sem_pkg::S_W'(py2);
        end
    end

endmodule
`default_nettype wire

// ===== design/sem_root.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_root
// rounded square root saturated at 255, one result bit per cycle per channel
// ----------------------------------------------------------------------------
module sem_root (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  sem_pkg::t_sq    i_sq,
    output logic            o_done,
    output sem_pkg::t_mag   o_mag
);

    sem_pkg::t_sq  r_sq;
    sem_pkg::t_mag r_n;
    sem_pkg::t_mag n_n;
    logic [2:0]    r_bit;
    logic          r_busy;

    // largest k with sq >= k*k - k + 1, searched from the top bit down
    always_comb begin
        logic [sem_pkg::CH_W-1:0]   cand;
        logic [2*sem_pkg::CH_W-1:0] k2;
        logic [2*sem_pkg::CH_W:0]   thr;
        for (int ch = 0; ch < 3; ch++) begin
            cand = r_n[ch] | (sem_pkg::CH_W'(1) << r_bit);
            k2   = cand * cand;
            thr  = {1'b0, k2} - (2*sem_pkg::CH_W+1)'(cand) + (2*sem_pkg::CH_W+1)'(1);
            n_n[ch] = (r_sq[ch] >= sem_pkg::S_W'(thr)) ? cand : r_n[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_bit  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            o_done <= 1'b0;
            r_bit  <= 3'd7;
        end else if (r_busy) begin
            r_bit <= r_bit - 3'd1;
            if (r_bit == 3'd0) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sq <= i_sq;
            r_n  <= '0;
        end else if (r_busy) begin
            r_n <= n_n;
        end
    end

    assign o_mag = r_n;

endmodule
`default_nettype wire

// ===== design/sobel_edge_magnitude_rgb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// per-channel 3x3 sobel gradient magnitude over an rgb raster stream
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one word at a time; a word with tuser set is a
// flush tick and counts as a black pixel. The result for a position leaves
// with the word accepted width+1 positions later, so a frame needs width+1
// words after its last pixel. An item that yields no result is accepted, then
// its line store is read and written back; an item that yields a result goes
// on through the gradient step, the 8-step bit-serial root and the hand-off
// into the output register, waiting while that register stays full. The
// output register lets the next word in while a result waits. Line stores
// need no clearing pass.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [sem_pkg::PIX_W-1:0]        s_axis_tdata,   // red_in, green_in, blue_in
    input  wire                              s_axis_tuser,   // kind
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [sem_pkg::PIX_W-1:0]        m_axis_tdata,   // red_edge, green_edge, blue_edge
    output logic                             m_axis_tlast,   // last_of_row
    output logic                             m_axis_tuser,   // last_of_frame
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [sem_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [sem_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CL_W  = 18;
    localparam int P_W   = sem_pkg::IROW_W + W_W;
    localparam int RST_W = (sem_pkg::RESET_WIDTH < MAX_WIDTH) ? sem_pkg::RESET_WIDTH : MAX_WIDTH;
    localparam int RST_H = (sem_pkg::RESET_HEIGHT < MAX_HEIGHT) ? sem_pkg::RESET_HEIGHT
                                                                : MAX_HEIGHT;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_GRAD, S_ROOT} t_state;

    t_state                       r_state;
    logic [W_W-1:0]               r_w;
    logic [H_W-1:0]               r_h;
    logic [COL_W-1:0]             r_icol;
    logic [sem_pkg::IROW_W-1:0]   r_irow;
    logic [W_W-1:0]               r_ocol;
    logic [H_W-1:0]               r_orow;
    logic [COL_W-1:0]             r_col;
    sem_pkg::t_pix                r_px;
    sem_pkg::t_border             r_border;
    logic                         r_produce;
    logic                         r_end_row;
    logic                         r_end_frame;

    logic                         in_acc;
    logic                         out_free;
    logic                         out_load;
    logic                         produce;
    logic                         end_row;
    logic                         end_frame;
    logic [P_W-1:0]               pos;
    logic [CL_W-1:0]              cfg_w;
    logic [CL_W-1:0]              cfg_h;
    logic [2*sem_pkg::PIX_W-1:0]  mem_rd;
    sem_pkg::t_sq                 sq;
    sem_pkg::t_mag                mag;
    logic                         root_done;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign out_load      = (r_state == S_ROOT) && root_done && out_free;

    assign pos       = P_W'(r_irow) * P_W'(r_w) + P_W'(r_icol);
    assign produce   = pos >= (P_W'(r_w) + P_W'(1));
    assign end_row   = ((W_W+1)'(r_ocol) + (W_W+1)'(1)) >= (W_W+1)'(r_w);
    assign end_frame = end_row && (((H_W+1)'(r_orow) + (H_W+1)'(1)) >= (H_W+1)'(r_h));

    // out-of-range writes clamp to 1..max
    always_comb begin
        cfg_w = CL_W'(i_cfg_data[sem_pkg::WIDTH_FIELD_W-1:0]);
        if (cfg_w == '0) cfg_w = CL_W'(1);
        if (cfg_w > CL_W'(MAX_WIDTH)) cfg_w = CL_W'(MAX_WIDTH);
        cfg_h = CL_W'(i_cfg_data[sem_pkg::HEIGHT_FIELD_W-1:0]);
        if (cfg_h == '0) cfg_h = CL_W'(1);
        if (cfg_h > CL_W'(MAX_HEIGHT)) cfg_h = CL_W'(MAX_HEIGHT);
    end

    sem_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (r_icol),
        .o_rd_data (mem_rd),
        .i_wr_en   (r_state == S_READ),
        .i_wr_addr (r_col),
        .i_wr_data ({mem_rd[sem_pkg::PIX_W-1:0], r_px})
    );

    sem_grad u_grad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (r_state == S_READ),
        .i_upper  (mem_rd[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W]),
        .i_middle (mem_rd[sem_pkg::PIX_W-1:0]),
        .i_px     (r_px),
        .i_border (r_border),
        .o_sq     (sq)
    );

    sem_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_GRAD),
        .i_sq    (sq),
        .o_done  (root_done),
        .o_mag   (mag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_w           <= W_W'(RST_W);
            r_h           <= H_W'(RST_H);
            r_icol        <= '0;
            r_irow        <= '0;
            r_ocol        <= '0;
            r_orow        <= '0;
            r_produce     <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == sem_pkg::REG_FRAME_WIDTH) begin
                r_w <= W_W'(cfg_w);
            end
            if (i_cfg_valid && i_cfg_index == sem_pkg::REG_FRAME_HEIGHT) begin
                r_h <= H_W'(cfg_h);
            end
            if (out_load) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_produce <= produce;
                        r_state   <= S_READ;
                        if (produce && end_frame) begin
                            r_icol <= '0;
                            r_irow <= '0;
                            r_ocol <= '0;
                            r_orow <= '0;
                        end else begin
                            if (produce) begin
                                if (end_row) begin
                                    r_ocol <= '0;
                                    r_orow <= r_orow + H_W'(1);
                                end else begin
                                    r_ocol <= r_ocol + W_W'(1);
                                end
                            end
                            if (((W_W+1)'(r_icol) + (W_W+1)'(1)) >= (W_W+1)'(r_w)) begin
                                r_icol <= '0;
                                if (r_irow != '1) r_irow <= r_irow + sem_pkg::IROW_W'(1);
                            end else begin
                                r_icol <= r_icol + COL_W'(1);
                            end
                        end
                    end
                end
                S_READ: begin
                    r_state <= r_produce ? S_GRAD : S_IDLE;
                end
                S_GRAD: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_px               <= s_axis_tuser ? '0 : s_axis_tdata;
            r_col              <= r_icol;
            r_end_row          <= end_row;
            r_end_frame        <= end_frame;
            r_border.row_top   <= r_orow != '0;
            r_border.row_bot   <= ((H_W+1)'(r_orow) + (H_W+1)'(1)) < (H_W+1)'(r_h);
            r_border.col_left  <= r_ocol != '0;
            r_border.col_right <= !end_row;
        end
        if (out_load) begin
            m_axis_tdata <= mag;
            m_axis_tlast <= r_end_row;
            m_axis_tuser <= r_end_frame;
        end
    end

    a_grad_after_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRAD) |-> ($past(r_state) == S_READ && $past(r_produce)))
        else $error("gradient step without a producing read");

    a_out_from_root : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_ROOT && $past(root_done)))
        else $error("result loaded before the root finished");

    a_frame_end_is_row_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("frame end flagged off a row end");

    a_accept_reads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_READ))
        else $error("accepted word did not start a read");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the rgb sobel edge magnitude stream block
// ----------------------------------------------------------------------------
// Frames of rgb words are streamed in raster order with flush ticks after the
// last pixel. A local model of the line stores, the window and the border
// masks predicts every edge word, and a monitor compares each output word,
// field by field, against the oldest prediction. The frame size registers are
// rewritten between frames, including out-of-range and ignored writes. The
// sender works in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import sem_pkg::*;

    localparam int LINE_DEPTH = DEF_MAX_WIDTH;
    localparam int SETTLE_CYC = 30;

    typedef struct {
        logic [PIX_W-1:0] edges;
        bit               row_end;
        bit               frame_end;
    } t_edge_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata;   // red_in, green_in, blue_in
    logic                  s_axis_tuser;   // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [PIX_W-1:0]      m_axis_tdata;   // red_edge, green_edge, blue_edge
    logic                  m_axis_tlast;   // last_of_row
    logic                  m_axis_tuser;   // last_of_frame
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sobel_edge_magnitude_rgb dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // model state
    int               frame_w;
    int               frame_h;
    logic [PIX_W-1:0] upper_line [LINE_DEPTH];
    logic [PIX_W-1:0] middle_line [LINE_DEPTH];
    logic [PIX_W-1:0] win [3][3];
    int               in_col, in_row, out_col, out_row;

    t_edge_word pending_edges[$];
    int         mismatches;
    int         edge_words;
    int         words_sent;
    int         frames_sent;
    int         burst_left;

    const int kx[3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
    const int ky[3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("timeout with %0d edge words outstanding", pending_edges.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // rounded root by counting thresholds k^2-k+1
    function automatic logic [CH_W-1:0] edge_mag(int gx, int gy);
        int               s;
        logic [CH_W-1:0]  n;
        n = '0;
        s = gx * gx + gy * gy;
        for (int k = 1; k <= 255; k++) begin
            if (s >= k * k - k + 1) n = CH_W'(k);
            else break;
        end
        return n;
    endfunction

    task automatic model_reset();
        frame_w = RESET_WIDTH;
        frame_h = RESET_HEIGHT;
        for (int i = 0; i < LINE_DEPTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) win[r][c] = '0;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endtask

    task automatic model_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        int v;
        if (idx == REG_FRAME_WIDTH) begin
            v = int'(val[WIDTH_FIELD_W-1:0]);
            frame_w = (v < 1) ? 1 : (v > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : v;
        end else if (idx == REG_FRAME_HEIGHT) begin
            v = int'(val[HEIGHT_FIELD_W-1:0]);
            frame_h = (v < 1) ? 1 : (v > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : v;
        end
    endtask

    // advances the window by one accepted word and queues any edge word
    task automatic predict_edges(bit kind, logic [PIX_W-1:0] pix);
        int               col, gx, gy, v;
        bit               rok[3], cok[3];
        bit               erow, efr;
        logic [PIX_W-1:0] p;
        t_edge_word       e;
        p   = kind ? '0 : pix;
        col = (in_col < LINE_DEPTH) ? in_col : 0;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = upper_line[col];
        win[1][2] = middle_line[col];
        win[2][2] = p;
        upper_line[col]  = middle_line[col];
        middle_line[col] = p;

        if (in_row * frame_w + in_col >= frame_w + 1) begin
            erow = (out_col + 1 >= frame_w);
            efr  = erow && (out_row + 1 >= frame_h);
            rok[0] = out_row > 0;  rok[1] = 1'b1; rok[2] = out_row + 1 < frame_h;
            cok[0] = out_col > 0;  cok[1] = 1'b1; cok[2] = out_col + 1 < frame_w;
            for (int ch = 0; ch < 3; ch++) begin
                gx = 0; gy = 0;
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        if (rok[r] && cok[c]) begin
                            v  = int'(win[r][c][CH_W*ch +: CH_W]);
                            gx += v * kx[r][c];
                            gy += v * ky[r][c];
                        end
                e.edges[CH_W*ch +: CH_W] = edge_mag(gx, gy);
            end
            e.row_end   = erow;
            e.frame_end = efr;
            pending_edges.push_back(e);
            if (efr) begin
                in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                return;
            end
            if (erow) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col++;
            end
        end
        if (in_col + 1 >= frame_w) begin
            in_col = 0;
            if (in_row < 8191) in_row++;
        end else begin
            in_col++;
        end
    endtask

    task automatic send_word(bit kind, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                             logic [CH_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {b, g, r};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_edges(kind, {b, g, r});
        words_sent++;
    endtask

    // stop sending until every edge word is out and the block has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        model_config(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    // one whole frame, pixels then the flush tail; noise adds flush ticks
    // inside the frame and random words in the tail
    task automatic send_frame(int noise_pct);
        int n;
        n = frame_w * frame_h;
        for (int i = 0; i < n; i++)
            send_word($urandom_range(0, 99) < noise_pct, rand_chan(), rand_chan(),
                      rand_chan());
        for (int i = 0; i <= frame_w; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_word(1'b0, rand_chan(), rand_chan(), rand_chan());
            else
                send_word(1'b1, '0, '0, '0);
        end
        frames_sent++;
    endtask

    task automatic test_directed();
        drain();
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        send_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
        send_word(1'b0, 8'h00, 8'h00, 8'h00);
        send_word(1'b0, 8'hFF, 8'h00, 8'hFF);
        send_word(1'b0, 8'h00, 8'hFF, 8'h00);
        send_word(1'b1, 8'hFF, 8'hFF, 8'hFF);   // flush inside the frame
        send_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
        send_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
        send_word(1'b0, 8'h00, 8'h00, 8'h00);
        send_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
        for (int i = 0; i < 4; i++) send_word(1'b1, '0, '0, '0);
        frames_sent++;
        // single-pixel frame
        drain();
        write_reg(REG_FRAME_WIDTH, 13'd1);
        write_reg(REG_FRAME_HEIGHT, 13'd1);
        send_word(1'b0, 8'hFF, 8'h80, 8'h01);
        send_word(1'b0, 8'hAA, 8'h55, 8'hFF);   // past the bottom: data unused
        send_word(1'b1, '0, '0, '0);
        frames_sent++;
    endtask

    task automatic test_register_limits();
        drain();
        write_reg(REG_FRAME_WIDTH, 13'd0);         // zero clamps to one
        write_reg(REG_FRAME_HEIGHT, 13'd0);
        send_frame(0);
        drain();
        write_reg(REG_FRAME_WIDTH, 13'h0805);      // bits above the field drop
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        write_reg(CFG_IDX_W'(2), 13'd7);           // no such register
        write_reg(CFG_IDX_W'(255), 13'h1FFF);
        send_frame(10);
        drain();
        write_reg(REG_FRAME_WIDTH, 13'd2047);      // saturating writes, then replaced
        write_reg(REG_FRAME_HEIGHT, 13'd8191);
        write_reg(REG_FRAME_WIDTH, 13'd12);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        send_frame(5);
    endtask

    task automatic test_random_frames();
        while (words_sent < 1380) begin
            if ($urandom_range(0, 2) != 0) begin
                drain();
                write_reg(REG_FRAME_WIDTH, ($urandom_range(0, 9) == 0)
                          ? CFG_DATA_W'($urandom_range(13, 40))
                          : CFG_DATA_W'($urandom_range(1, 9)));
                write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(1, 7)));
            end
            send_frame(($urandom_range(0, 3) == 0) ? 25 : 0);
        end
    endtask

    // receiver stall pattern, reshuffled whenever its counter runs out
    int rx_mode, rx_count;
    always @(posedge i_clk) begin
        if (rx_count == 0) begin
            rx_mode  <= $urandom_range(0, 3);
            rx_count <= 64;
        end else begin
            rx_count <= rx_count - 1;
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_count[3:0] < 4'd12);
        endcase
    end

    always @(posedge i_clk) begin
        t_edge_word e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            edge_words++;
            if (pending_edges.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected edge word %h last %b/%b", m_axis_tdata,
                             m_axis_tlast, m_axis_tuser);
            end else begin
                e = pending_edges.pop_front();
                if (m_axis_tdata !== e.edges || m_axis_tlast !== e.row_end
                        || m_axis_tuser !== e.frame_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("edge word %0d: expected %h last %b/%b, got %h last %b/%b",
                                 edge_words, e.edges, e.row_end, e.frame_end,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        rx_mode       = 0;
        rx_count      = 0;
        mismatches    = 0;
        edge_words    = 0;
        words_sent    = 0;
        frames_sent   = 0;
        burst_left    = 0;
        model_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_register_limits();
        test_random_frames();

        s_axis_tvalid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("%0d words in %0d frames, %0d edge words checked, %0d mismatches",
                 words_sent, frames_sent, edge_words, mismatches);
        $display("frames from 1x1 to 40x7, clamped and ignored register writes, flush ticks and stalls");
        if (mismatches == 0 && pending_edges.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
